/* src/gda_pkg.sv */
// shared types, constants and table functions of the gregorian date arithmetic core
package gda_pkg;

  localparam int MODE_W  = 2;
  localparam int DIN_W   = 6;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int DYS_W   = 22;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 23;
  localparam int STAT_W  = 2;
  localparam int REM_W   = 23;
  localparam int ACC_W   = 24;
  localparam int OFF_W   = 10;
  localparam int LVL_W   = 2;
  localparam int IDX_W   = 3;

  localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIFF = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  localparam logic [LVL_W-1:0] LVL_400Y = 2'd0;
  localparam logic [LVL_W-1:0] LVL_100Y = 2'd1;
  localparam logic [LVL_W-1:0] LVL_4Y   = 2'd2;
  localparam logic [LVL_W-1:0] LVL_1Y   = 2'd3;

  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  // years covered by one unit of each cycle level
  function automatic logic [8:0] lvl_years(input logic [LVL_W-1:0] lvl);
    logic [8:0] r;
    case (lvl)
      LVL_400Y: r = 9'd400;
      LVL_100Y: r = 9'd100;
      LVL_4Y:   r = 9'd4;
      default:  r = 9'd1;
    endcase
    return r;
  endfunction

  // days covered by one unit of each cycle level
  function automatic logic [17:0] lvl_days(input logic [LVL_W-1:0] lvl);
    logic [17:0] r;
    case (lvl)
      LVL_400Y: r = 18'd146097;
      LVL_100Y: r = 18'd36524;
      LVL_4Y:   r = 18'd1461;
      default:  r = 18'd365;
    endcase
    return r;
  endfunction

  // highest quotient bit examined at each level
  function automatic logic [IDX_W-1:0] lvl_top(input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] r;
    case (lvl)
      LVL_400Y: r = 3'd5;
      LVL_100Y: r = 3'd1;
      LVL_4Y:   r = 3'd4;
      default:  r = 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [MON_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      r = 5'd30;
    end else if (m == MON_FEB) begin
      r = leap ? 5'd29 : 5'd28;
    end else begin
      r = 5'd31;
    end
    return r;
  endfunction

endpackage

/* src/gda_in_if.sv */
// command channel of the date core: mode and date operands
interface gda_in_if;
  logic                             valid;
  logic                             ready;
  logic [gda_pkg::MODE_W-1:0]       mode;
  logic [gda_pkg::DIN_W-1:0]        day_in;
  logic [gda_pkg::MON_W-1:0]        month_in;
  logic [gda_pkg::YEAR_W-1:0]       year_in;
  logic [gda_pkg::DYS_W-1:0]        days_to_subtract;

  modport source (output valid, mode, day_in, month_in, year_in, days_to_subtract,
                  input ready);
  modport sink (input valid, mode, day_in, month_in, year_in, days_to_subtract,
                output ready);
endinterface

/* src/gda_out_if.sv */
// result channel of the date core: stored date, difference and status
interface gda_out_if;
  logic                              valid;
  logic                              ready;
  logic [gda_pkg::DAY_W-1:0]         day_out;
  logic [gda_pkg::MON_W-1:0]         month_out;
  logic [gda_pkg::YEAR_W-1:0]        year_out;
  logic signed [gda_pkg::DIFF_W-1:0] difference;
  logic [gda_pkg::STAT_W-1:0]        status;

  modport source (output valid, day_out, month_out, year_out, difference, status,
                  input ready);
  modport sink (input valid, day_out, month_out, year_out, difference, status,
                output ready);
endinterface

/* src/gregorian_date_arithmetic_core.sv */
// gregorian date arithmetic core: stored date with load, subtract and difference
// usage:
//   in_ch carries one command beat: mode, day_in, month_in, year_in, days_to_subtract.
//   out_ch returns exactly one beat per command: the stored date after the command,
//   the signed difference (mode 2 only, else 0) and a status code.
//   load (mode 0) and no-op (mode 3) go from accept straight to the done state.
//   subtract with days_to_subtract below the stored day does so as well.
//   a full subtract converts the date to a day serial (15 steps), subtracts, then
//   converts back (15 steps) and walks up to 11 months.
//   difference converts two dates to serials.
//   every step goes through one conditional subtract/accumulate unit that peels
//   400, 100, 4 and 1 year blocks a quotient bit at a time; that unit sets the time.
//   in_ch.ready is high only while the sequencer is idle, one command at a time.
//   results sit in an output register; a new command may be accepted while the
//   last result waits, but its own result holds until out_ch.ready frees the register.
//   reset (rst_n low, synchronous) sets the stored date to 1/1/1 and drops out valid.
module gregorian_date_arithmetic_core (
  input  logic          clk,
  input  logic          rst_n,
  gda_in_if.sink        in_ch,
  gda_out_if.source     out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_FINF  = 3'd2;
  localparam logic [2:0] S_SUBDY = 3'd3;
  localparam logic [2:0] S_MWALK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                       state_r, state_nxt;
  logic [gda_pkg::MODE_W-1:0]       mode_r, mode_nxt;
  logic [gda_pkg::DAY_W-1:0]        gd_r, gd_nxt;
  logic [gda_pkg::MON_W-1:0]        gm_r, gm_nxt;
  logic [gda_pkg::DYS_W-1:0]        dy_r, dy_nxt;
  logic [gda_pkg::DAY_W-1:0]        cur_day_r, cur_day_nxt;
  logic [gda_pkg::MON_W-1:0]        cur_month_r, cur_month_nxt;
  logic [gda_pkg::YEAR_W-1:0]       cur_year_r, cur_year_nxt;
  logic [gda_pkg::REM_W-1:0]        rem_r, rem_nxt;
  logic [gda_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [gda_pkg::LVL_W-1:0]        lvl_r, lvl_nxt;
  logic [gda_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic                             fwd_r, fwd_nxt;
  logic                             giv_r, giv_nxt;
  logic                             neg_r, neg_nxt;
  logic [1:0]                       qb_r, qb_nxt;
  logic [4:0]                       qc_r, qc_nxt;
  logic [1:0]                       qe_r, qe_nxt;
  logic [gda_pkg::MON_W-1:0]        mw_r, mw_nxt;
  logic [gda_pkg::DIFF_W-1:0]       diff_r, diff_nxt;
  logic [gda_pkg::STAT_W-1:0]       status_r, status_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [gda_pkg::DAY_W-1:0]        out_day_r, out_day_nxt;
  logic [gda_pkg::MON_W-1:0]        out_month_r, out_month_nxt;
  logic [gda_pkg::YEAR_W-1:0]       out_year_r, out_year_nxt;
  logic [gda_pkg::DIFF_W-1:0]       out_diff_r, out_diff_nxt;
  logic [gda_pkg::STAT_W-1:0]       out_status_r, out_status_nxt;

  logic                             in_beat;
  logic                             in_ok;
  logic                             leap;
  logic [gda_pkg::DAY_W-1:0]        sel_d;
  logic [gda_pkg::MON_W-1:0]        sel_m;
  logic [gda_pkg::OFF_W-1:0]        off;
  logic [gda_pkg::REM_W-1:0]        div_days, div_years;
  logic [gda_pkg::REM_W-1:0]        dv, av;
  logic [gda_pkg::ACC_W-1:0]        rem_diff;
  logic                             fits;
  logic [gda_pkg::ACC_W-1:0]        acc_b;
  logic                             acc_sub;
  logic [gda_pkg::ACC_W-1:0]        acc_sum;
  logic                             out_free;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_beat           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.day_out    = out_day_r;
  assign out_ch.month_out  = out_month_r;
  assign out_ch.year_out   = out_year_r;
  assign out_ch.difference = out_diff_r;
  assign out_ch.status     = out_status_r;
  assign out_free          = !out_valid_r || out_ch.ready;

  assign in_ok = (in_ch.day_in >= 6'd1) && (in_ch.day_in <= 6'd31) &&
                 (in_ch.month_in >= 4'd1) && (in_ch.month_in <= gda_pkg::MON_DEC) &&
                 (in_ch.year_in >= 14'd1) && (in_ch.year_in <= gda_pkg::MAX_YEAR);

  // leap year from the block quotients of year-1 (100s, 4s, 1s)
  assign leap = (qe_r == 2'd3) && ((qc_r != 5'd24) || (qb_r == 2'd3));

  assign sel_d = giv_r ? gd_r : cur_day_r;
  assign sel_m = giv_r ? gm_r : cur_month_r;

  // day-of-year offset; subtract path folds in the serial-to-zero-based minus one
  assign off = gda_pkg::OFF_W'(gda_pkg::days_before_month(sel_m))
             + gda_pkg::OFF_W'((sel_m > gda_pkg::MON_FEB) && leap)
             + gda_pkg::OFF_W'(sel_d)
             - gda_pkg::OFF_W'(mode_r == gda_pkg::MODE_SUB);

  assign div_days  = gda_pkg::REM_W'(gda_pkg::lvl_days(lvl_r)) << idx_r;
  assign div_years = gda_pkg::REM_W'(gda_pkg::lvl_years(lvl_r)) << idx_r;

  always_comb begin
    if (state_r == S_MWALK) begin
      dv = gda_pkg::REM_W'(gda_pkg::month_len(mw_r, leap));
      av = div_years;
    end else begin
      dv = fwd_r ? div_years : div_days;
      av = fwd_r ? div_days : div_years;
    end
  end

  // shared unit: trial subtract on the remainder, add/subtract on the accumulator
  assign rem_diff = {1'b0, rem_r} - {1'b0, dv};
  assign fits     = !rem_diff[gda_pkg::ACC_W-1];

  always_comb begin
    case (state_r)
      S_FINF: begin
        acc_b   = gda_pkg::ACC_W'(off);
        acc_sub = neg_r;
      end
      S_SUBDY: begin
        acc_b   = gda_pkg::ACC_W'(dy_r);
        acc_sub = 1'b1;
      end
      default: begin
        acc_b   = {1'b0, av};
        acc_sub = neg_r;
      end
    endcase
  end

  assign acc_sum = acc_r + (acc_b ^ {gda_pkg::ACC_W{acc_sub}})
                 + gda_pkg::ACC_W'(acc_sub);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    gd_nxt         = gd_r;
    gm_nxt         = gm_r;
    dy_nxt         = dy_r;
    cur_day_nxt    = cur_day_r;
    cur_month_nxt  = cur_month_r;
    cur_year_nxt   = cur_year_r;
    rem_nxt        = rem_r;
    acc_nxt        = acc_r;
    lvl_nxt        = lvl_r;
    idx_nxt        = idx_r;
    fwd_nxt        = fwd_r;
    giv_nxt        = giv_r;
    neg_nxt        = neg_r;
    qb_nxt         = qb_r;
    qc_nxt         = qc_r;
    qe_nxt         = qe_r;
    mw_nxt         = mw_r;
    diff_nxt       = diff_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_day_nxt    = out_day_r;
    out_month_nxt  = out_month_r;
    out_year_nxt   = out_year_r;
    out_diff_nxt   = out_diff_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          mode_nxt   = in_ch.mode;
          gd_nxt     = in_ch.day_in[gda_pkg::DAY_W-1:0];
          gm_nxt     = in_ch.month_in;
          dy_nxt     = in_ch.days_to_subtract;
          diff_nxt   = '0;
          status_nxt = gda_pkg::STAT_OK;
          acc_nxt    = '0;
          lvl_nxt    = gda_pkg::LVL_400Y;
          idx_nxt    = gda_pkg::lvl_top(gda_pkg::LVL_400Y);
          fwd_nxt    = 1'b1;
          giv_nxt    = 1'b0;
          neg_nxt    = 1'b0;
          qb_nxt     = '0;
          qc_nxt     = '0;
          qe_nxt     = '0;
          rem_nxt    = gda_pkg::REM_W'(cur_year_r - 14'd1);
          state_nxt  = S_DONE;
          case (in_ch.mode)
            gda_pkg::MODE_LOAD: begin
              if (in_ok) begin
                cur_day_nxt   = in_ch.day_in[gda_pkg::DAY_W-1:0];
                cur_month_nxt = in_ch.month_in;
                cur_year_nxt  = in_ch.year_in;
              end else begin
                status_nxt = gda_pkg::STAT_INVALID;
              end
            end
            gda_pkg::MODE_SUB: begin
              if (gda_pkg::DYS_W'(cur_day_r) > in_ch.days_to_subtract) begin
                cur_day_nxt = cur_day_r - in_ch.days_to_subtract[gda_pkg::DAY_W-1:0];
              end else begin
                state_nxt = S_DIV;
              end
            end
            gda_pkg::MODE_DIFF: begin
              if (in_ok) begin
                // given date first, accumulated negative
                giv_nxt   = 1'b1;
                neg_nxt   = 1'b1;
                rem_nxt   = gda_pkg::REM_W'(in_ch.year_in - 14'd1);
                state_nxt = S_DIV;
              end else begin
                status_nxt = gda_pkg::STAT_INVALID;
              end
            end
            default: begin
              status_nxt = gda_pkg::STAT_OK;
            end
          endcase
        end
      end

      S_DIV: begin
        if (fits) begin
          rem_nxt = rem_diff[gda_pkg::REM_W-1:0];
          acc_nxt = acc_sum;
        end
        case (lvl_r)
          gda_pkg::LVL_100Y: qb_nxt = {qb_r[0], fits};
          gda_pkg::LVL_4Y:   qc_nxt = {qc_r[3:0], fits};
          gda_pkg::LVL_1Y:   qe_nxt = {qe_r[0], fits};
          default:           qb_nxt = qb_r;
        endcase
        if (idx_r == '0) begin
          if (lvl_r == gda_pkg::LVL_1Y) begin
            if (fwd_r) begin
              state_nxt = S_FINF;
            end else begin
              mw_nxt    = 4'd1;
              state_nxt = S_MWALK;
            end
          end else begin
            lvl_nxt = lvl_r + 2'd1;
            idx_nxt = gda_pkg::lvl_top(lvl_r + 2'd1);
          end
        end else begin
          idx_nxt = idx_r - 3'd1;
        end
      end

      S_FINF: begin
        acc_nxt = acc_sum;
        if (mode_r == gda_pkg::MODE_SUB) begin
          state_nxt = S_SUBDY;
        end else if (giv_r) begin
          // second pass on the stored date, accumulator keeps minus given serial
          giv_nxt   = 1'b0;
          neg_nxt   = 1'b0;
          rem_nxt   = gda_pkg::REM_W'(cur_year_r - 14'd1);
          lvl_nxt   = gda_pkg::LVL_400Y;
          idx_nxt   = gda_pkg::lvl_top(gda_pkg::LVL_400Y);
          qb_nxt    = '0;
          qc_nxt    = '0;
          qe_nxt    = '0;
          state_nxt = S_DIV;
        end else begin
          // saturate to the output range
          if (acc_sum[gda_pkg::ACC_W-1] != acc_sum[gda_pkg::ACC_W-2]) begin
            diff_nxt = acc_sum[gda_pkg::ACC_W-1] ? {1'b1, {(gda_pkg::DIFF_W-1){1'b0}}}
                                                 : {1'b0, {(gda_pkg::DIFF_W-1){1'b1}}};
          end else begin
            diff_nxt = acc_sum[gda_pkg::DIFF_W-1:0];
          end
          state_nxt = S_DONE;
        end
      end

      S_SUBDY: begin
        if (acc_sum[gda_pkg::ACC_W-1]) begin
          status_nxt = gda_pkg::STAT_UNDERFLOW;
          state_nxt  = S_DONE;
        end else begin
          rem_nxt   = acc_sum[gda_pkg::REM_W-1:0];
          acc_nxt   = '0;
          fwd_nxt   = 1'b0;
          neg_nxt   = 1'b0;
          lvl_nxt   = gda_pkg::LVL_400Y;
          idx_nxt   = gda_pkg::lvl_top(gda_pkg::LVL_400Y);
          qb_nxt    = '0;
          qc_nxt    = '0;
          qe_nxt    = '0;
          state_nxt = S_DIV;
        end
      end

      S_MWALK: begin
        if ((mw_r < gda_pkg::MON_DEC) && fits) begin
          rem_nxt = rem_diff[gda_pkg::REM_W-1:0];
          mw_nxt  = mw_r + 4'd1;
        end else begin
          cur_day_nxt   = rem_r[gda_pkg::DAY_W-1:0] + 5'd1;
          cur_month_nxt = mw_r;
          cur_year_nxt  = acc_r[gda_pkg::YEAR_W-1:0] + 14'd1;
          state_nxt     = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_day_nxt    = cur_day_r;
          out_month_nxt  = cur_month_r;
          out_year_nxt   = cur_year_r;
          out_diff_nxt   = diff_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cur_day_r   <= 5'd1;
      cur_month_r <= 4'd1;
      cur_year_r  <= 14'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_month_r <= cur_month_nxt;
      cur_year_r  <= cur_year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    gd_r         <= gd_nxt;
    gm_r         <= gm_nxt;
    dy_r         <= dy_nxt;
    rem_r        <= rem_nxt;
    acc_r        <= acc_nxt;
    lvl_r        <= lvl_nxt;
    idx_r        <= idx_nxt;
    fwd_r        <= fwd_nxt;
    giv_r        <= giv_nxt;
    neg_r        <= neg_nxt;
    qb_r         <= qb_nxt;
    qc_r         <= qc_nxt;
    qe_r         <= qe_nxt;
    mw_r         <= mw_nxt;
    diff_r       <= diff_nxt;
    status_r     <= status_nxt;
    out_day_r    <= out_day_nxt;
    out_month_r  <= out_month_nxt;
    out_year_r   <= out_year_nxt;
    out_diff_r   <= out_diff_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

/* verif/tb.sv */
// self-checking testbench of the gregorian date arithmetic core
`timescale 1ns / 1ps

module tb;

  localparam logic [gda_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_CMDS    = 1680;
  localparam int CALM_CMDS      = 150;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam longint DIFF_HI    = (longint'(1) <<< (gda_pkg::DIFF_W - 1)) - 1;
  localparam longint DIFF_LO    = -(longint'(1) <<< (gda_pkg::DIFF_W - 1));

  typedef struct {
    logic [gda_pkg::MODE_W-1:0] mode;
    logic [gda_pkg::DIN_W-1:0]  day;
    logic [gda_pkg::MON_W-1:0]  month;
    logic [gda_pkg::YEAR_W-1:0] year;
    logic [gda_pkg::DYS_W-1:0]  span;
  } date_cmd_t;

  typedef struct {
    logic [gda_pkg::DAY_W-1:0]         day;
    logic [gda_pkg::MON_W-1:0]         month;
    logic [gda_pkg::YEAR_W-1:0]        year;
    logic signed [gda_pkg::DIFF_W-1:0] diff;
    logic [gda_pkg::STAT_W-1:0]        status;
  } date_res_t;

  typedef struct {
    date_cmd_t cmd;
    bit        typed;
    date_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  gda_in_if  in_ch();
  gda_out_if out_ch();

  gregorian_date_arithmetic_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns period
  always #2 clk = ~clk;

  // predictor state: the date the block should hold
  logic [gda_pkg::DAY_W-1:0]  held_day;
  logic [gda_pkg::MON_W-1:0]  held_month;
  logic [gda_pkg::YEAR_W-1:0] held_year;

  date_res_t expected_dates[$];
  stim_row_t directed_rows[$];

  // value that goes with the beat now on the command bus
  bit        drive_typed;
  date_res_t drive_res;

  bit calm;
  int errors;
  int cmds_accepted;
  int results_seen;
  int mode_hits[4];
  int status_hits[4];

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned len;
    case (m)
      4, 6, 9, 11: len = 30;
      2:           len = leap_year(y) ? 29 : 28;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic bit date_valid(int unsigned d, int unsigned m, int unsigned y);
    return d >= 1 && d <= 31 && m >= 1 && m <= 12 && y >= 1 && y <= gda_pkg::MAX_YEAR;
  endfunction

  // day number of a checked date, 1/1/1 is day 1
  function automatic longint day_number(int unsigned d, int unsigned m, int unsigned y);
    longint p;
    longint n;
    int unsigned k;
    p = longint'(y) - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (k = 1; k < m; k++) n += days_in_month(k, y);
    return n + d;
  endfunction

  function automatic void set_held_from_number(longint s);
    longint n;
    longint q400;
    longint q100;
    longint q4;
    longint q1;
    int unsigned y;
    int unsigned m;
    n = s - 1;
    q400 = n / 146097;
    n = n % 146097;
    q100 = n / 36524;
    if (q100 > 3) q100 = 3;
    n -= q100 * 36524;
    q4 = n / 1461;
    n = n % 1461;
    q1 = n / 365;
    if (q1 > 3) q1 = 3;
    n -= q1 * 365;
    y = int'(q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1);
    m = 1;
    while (m < 12 && n >= days_in_month(m, y)) begin
      n -= days_in_month(m, y);
      m++;
    end
    held_day   = gda_pkg::DAY_W'(n + 1);
    held_month = gda_pkg::MON_W'(m);
    held_year  = gda_pkg::YEAR_W'(y);
  endfunction

  function automatic date_res_t next_date_result(date_cmd_t c);
    date_res_t r;
    longint s;
    r.diff   = '0;
    r.status = gda_pkg::STAT_OK;
    case (c.mode)
      gda_pkg::MODE_LOAD: begin
        if (date_valid(c.day, c.month, c.year)) begin
          held_day   = gda_pkg::DAY_W'(c.day);
          held_month = c.month;
          held_year  = c.year;
        end else begin
          r.status = gda_pkg::STAT_INVALID;
        end
      end
      gda_pkg::MODE_SUB: begin
        // a span below the stored day only lowers the day, even past month end
        if (held_day > c.span) begin
          held_day = gda_pkg::DAY_W'(held_day - c.span);
        end else begin
          s = day_number(held_day, held_month, held_year) - longint'(c.span);
          if (s < 1) r.status = gda_pkg::STAT_UNDERFLOW;
          else set_held_from_number(s);
        end
      end
      gda_pkg::MODE_DIFF: begin
        if (date_valid(c.day, c.month, c.year)) begin
          s = day_number(held_day, held_month, held_year) -
              day_number(c.day, c.month, c.year);
          if (s > DIFF_HI) s = DIFF_HI;
          if (s < DIFF_LO) s = DIFF_LO;
          r.diff = gda_pkg::DIFF_W'(s);
        end else begin
          r.status = gda_pkg::STAT_INVALID;
        end
      end
      default: ;
    endcase
    r.day   = held_day;
    r.month = held_month;
    r.year  = held_year;
    return r;
  endfunction

  function automatic date_cmd_t mk_cmd(logic [gda_pkg::MODE_W-1:0] mode, int d, int m,
                                       int y, int span);
    date_cmd_t c;
    c.mode  = mode;
    c.day   = gda_pkg::DIN_W'(d);
    c.month = gda_pkg::MON_W'(m);
    c.year  = gda_pkg::YEAR_W'(y);
    c.span  = gda_pkg::DYS_W'(span);
    return c;
  endfunction

  function automatic date_res_t mk_res(int d, int m, int y, int diff,
                                       logic [gda_pkg::STAT_W-1:0] st);
    date_res_t r;
    r.day    = gda_pkg::DAY_W'(d);
    r.month  = gda_pkg::MON_W'(m);
    r.year   = gda_pkg::YEAR_W'(y);
    r.diff   = gda_pkg::DIFF_W'(diff);
    r.status = st;
    return r;
  endfunction

  function automatic void add_typed(date_cmd_t c, date_res_t r);
    stim_row_t row;
    row.cmd   = c;
    row.typed = 1'b1;
    row.res   = r;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_free(date_cmd_t c);
    stim_row_t row;
    row.cmd   = c;
    row.typed = 1'b0;
    row.res   = mk_res(0, 0, 0, 0, gda_pkg::STAT_OK);
    directed_rows.push_back(row);
  endfunction

  // calendar-aware operand: leap and century years, month ends
  function automatic date_cmd_t with_valid_date(date_cmd_t c);
    case ($urandom_range(0, 7))
      0:       c.year = gda_pkg::YEAR_W'(1);
      1:       c.year = gda_pkg::MAX_YEAR;
      2:       c.year = gda_pkg::YEAR_W'(4 * $urandom_range(1, 2499));
      3:       c.year = gda_pkg::YEAR_W'(100 * $urandom_range(1, 99));
      4:       c.year = gda_pkg::YEAR_W'(400 * $urandom_range(1, 24));
      5:       c.year = gda_pkg::YEAR_W'($urandom_range(1, 4));
      default: c.year = gda_pkg::YEAR_W'($urandom_range(1, 9999));
    endcase
    c.month = gda_pkg::MON_W'($urandom_range(1, 12));
    if ($urandom_range(0, 3) == 0) c.day = gda_pkg::DIN_W'($urandom_range(28, 31));
    else c.day = gda_pkg::DIN_W'($urandom_range(1, 31));
    return c;
  endfunction

  function automatic date_cmd_t random_cmd();
    date_cmd_t c;
    int pick;
    c.day   = gda_pkg::DIN_W'($urandom_range(0, 63));
    c.month = gda_pkg::MON_W'($urandom_range(0, 15));
    c.year  = gda_pkg::YEAR_W'($urandom_range(0, 16383));
    c.span  = gda_pkg::DYS_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      c = with_valid_date(c);
      c.mode = gda_pkg::MODE_LOAD;
    end else if (pick < 26) begin
      c.mode = gda_pkg::MODE_LOAD;
    end else if (pick < 60) begin
      c.mode = gda_pkg::MODE_SUB;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
          c.span = gda_pkg::DYS_W'($urandom_range(0, 40));
        12, 13, 14, 15, 16:
          c.span = gda_pkg::DYS_W'($urandom_range(41, 2000));
        17, 18:
          c.span = gda_pkg::DYS_W'($urandom_range(2001, 400000));
        default:
          c.span = gda_pkg::DYS_W'($urandom);
      endcase
    end else if (pick < 88) begin
      c = with_valid_date(c);
      c.mode = gda_pkg::MODE_DIFF;
    end else if (pick < 94) begin
      c.mode = gda_pkg::MODE_DIFF;
    end else begin
      c.mode = MODE_NOP;
    end
    return c;
  endfunction

  task automatic compare_date_result(date_res_t exp, date_res_t got);
    if (got.day !== exp.day) begin
      $error("day_out: expected %0d, got %0d", exp.day, got.day);
      errors++;
    end
    if (got.month !== exp.month) begin
      $error("month_out: expected %0d, got %0d", exp.month, got.month);
      errors++;
    end
    if (got.year !== exp.year) begin
      $error("year_out: expected %0d, got %0d", exp.year, got.year);
      errors++;
    end
    if (got.diff !== exp.diff) begin
      $error("difference: expected %0d, got %0d", exp.diff, got.diff);
      errors++;
    end
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      errors++;
    end
  endtask

  // one command beat, with an optional burst of idle cycles ahead of it
  task automatic send_cmd(date_cmd_t c, bit typed, date_res_t r);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.mode             = c.mode;
    in_ch.day_in           = c.day;
    in_ch.month_in         = c.month;
    in_ch.year_in          = c.year;
    in_ch.days_to_subtract = c.span;
    drive_typed            = typed;
    drive_res              = r;
    in_ch.valid            = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // both channels are watched at the rising edge
  always @(posedge clk) begin : monitor
    date_cmd_t c;
    date_res_t p;
    date_res_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        c.mode  = in_ch.mode;
        c.day   = in_ch.day_in;
        c.month = in_ch.month_in;
        c.year  = in_ch.year_in;
        c.span  = in_ch.days_to_subtract;
        p = next_date_result(c);
        expected_dates.push_back(drive_typed ? drive_res : p);
        cmds_accepted++;
        mode_hits[c.mode]++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.day    = out_ch.day_out;
        got.month  = out_ch.month_out;
        got.year   = out_ch.year_out;
        got.diff   = out_ch.difference;
        got.status = out_ch.status;
        results_seen++;
        status_hits[got.status]++;
        if (expected_dates.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          compare_date_result(expected_dates.pop_front(), got);
        end
      end
    end
  end

  // result side: short random stalls, one long hold so the core backs up
  initial begin : result_sink
    int stall_left;
    bit hold_done;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    hold_done    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (!hold_done && cmds_accepted >= HOLD_AT) begin
        hold_done    = 1'b1;
        stall_left   = HOLD_CYCLES - 1;
        out_ch.ready = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(0, 3);
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    date_cmd_t c;
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.mode             = gda_pkg::MODE_LOAD;
    in_ch.day_in           = '0;
    in_ch.month_in         = '0;
    in_ch.year_in          = '0;
    in_ch.days_to_subtract = '0;
    drive_typed            = 1'b0;
    drive_res              = mk_res(0, 0, 0, 0, gda_pkg::STAT_OK);
    calm                   = 1'b0;
    errors                 = 0;
    held_day               = gda_pkg::DAY_W'(1);
    held_month             = gda_pkg::MON_W'(1);
    held_year              = gda_pkg::YEAR_W'(1);

    // state right after reset, then every load rejection
    add_typed(mk_cmd(gda_pkg::MODE_DIFF, 1, 1, 1, 0),
              mk_res(1, 1, 1, 0, gda_pkg::STAT_OK));
    add_typed(mk_cmd(MODE_NOP, 63, 15, 16383, 4194303),
              mk_res(1, 1, 1, 0, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_SUB, 0, 0, 0, 1),
              mk_res(1, 1, 1, 0, gda_pkg::STAT_UNDERFLOW));
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 31, 12, 9999, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 0, 6, 2000, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_INVALID));
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 32, 6, 2000, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_INVALID));
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 63, 15, 16383, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_INVALID));
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 15, 0, 2000, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_INVALID));
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 15, 13, 2000, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_INVALID));
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 15, 6, 0, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_INVALID));
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 15, 6, 10000, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_INVALID));
    // widest span of the calendar both ways
    add_typed(mk_cmd(gda_pkg::MODE_DIFF, 1, 1, 1, 0),
              mk_res(31, 12, 9999, 3652058, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_DIFF, 0, 1, 1, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_INVALID));
    add_typed(mk_cmd(gda_pkg::MODE_SUB, 0, 0, 0, 4194303),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_UNDERFLOW));
    add_typed(mk_cmd(gda_pkg::MODE_SUB, 0, 0, 0, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_SUB, 0, 0, 0, 30),
              mk_res(1, 12, 9999, 0, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_SUB, 0, 0, 0, 3652028),
              mk_res(1, 1, 1, 0, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_DIFF, 31, 12, 9999, 0),
              mk_res(1, 1, 1, -3652058, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 31, 12, 9999, 0),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_SUB, 0, 0, 0, 3652059),
              mk_res(31, 12, 9999, 0, gda_pkg::STAT_UNDERFLOW));
    // leap day borrow in a 400-year and in a plain century year
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 1, 3, 2000, 0),
              mk_res(1, 3, 2000, 0, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_SUB, 0, 0, 0, 1),
              mk_res(29, 2, 2000, 0, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 1, 3, 1900, 0),
              mk_res(1, 3, 1900, 0, gda_pkg::STAT_OK));
    add_typed(mk_cmd(gda_pkg::MODE_SUB, 0, 0, 0, 1),
              mk_res(28, 2, 1900, 0, gda_pkg::STAT_OK));
    // day 31 in a 30-day month, then a borrow across it
    add_typed(mk_cmd(gda_pkg::MODE_LOAD, 31, 4, 2023, 0),
              mk_res(31, 4, 2023, 0, gda_pkg::STAT_OK));
    add_free(mk_cmd(gda_pkg::MODE_SUB, 0, 0, 0, 31));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i >= RANDOM_CMDS - CALM_CMDS) calm = 1'b1;
      c = random_cmd();
      send_cmd(c, 1'b0, drive_res);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_dates.size() != 0) begin
      $error("%0d results never arrived", expected_dates.size());
      errors++;
    end

    $display("%0d commands: %0d loads, %0d subtracts, %0d differences, %0d no-ops",
             cmds_accepted, mode_hits[gda_pkg::MODE_LOAD], mode_hits[gda_pkg::MODE_SUB],
             mode_hits[gda_pkg::MODE_DIFF], mode_hits[MODE_NOP]);
    $display("%0d results checked: %0d ok, %0d rejected dates, %0d underflows",
             results_seen, status_hits[gda_pkg::STAT_OK],
             status_hits[gda_pkg::STAT_INVALID], status_hits[gda_pkg::STAT_UNDERFLOW]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
